// ===== sv/pbd_pkg.sv =====
// Shared types and constants for the Pauli basis decomposition unit.
package pbd_pkg;

    localparam int QUBITS_DEF = 3;
    localparam int ELEM_W     = 16;
    localparam int DATA_W     = 20;
    localparam int CODE_W     = 6;

    typedef struct packed {
        logic signed [ELEM_W-1:0] elem_re;
        logic signed [ELEM_W-1:0] elem_im;
    } elem_t;

    typedef struct packed {
        logic        [CODE_W-1:0] pauli_code;
        logic signed [DATA_W-1:0] coef_re;
        logic signed [DATA_W-1:0] coef_im;
        logic                     is_last;
    } coef_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
    } cval_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        cval_t   p;
        cval_t   q;
        alu_op_t op;
    } alu_req_t;

endpackage

// ===== sv/pbd_addsub.sv =====
// Shared complex add/subtract unit used by every butterfly write.
module pbd_addsub (
    input  pbd_pkg::alu_req_t req,
    output pbd_pkg::cval_t    res
);

    always_comb
    begin
        case (req.op)
            pbd_pkg::ALU_SUB:
            begin
                res.re = req.p.re - req.q.re;
                res.im = req.p.im - req.q.im;
            end
            default:
            begin
                res.re = req.p.re + req.q.re;
                res.im = req.p.im + req.q.im;
            end
        endcase
    end

endmodule

// ===== sv/pauli_basis_decomposition_unit.sv =====
// Pauli basis decomposition: load a 2^QUBITS square complex matrix in row-major
// order, one entry per accepted beat, into an internal store. The last entry
// starts QUBITS passes of quadrant butterflies (I=A+D, X=B+C, Y=i(B-C), Z=A-D),
// each butterfly reading its four entries over two read ports (S_RD0 to S_RD2)
// and writing them back through the single write port and one shared add/sub
// unit (S_WR0 to S_WR3). Then all 4^QUBITS coefficients leave in increasing
// pauli_code order, each held until taken, the final one with is_last set.
// Coefficients are scaled by 2^QUBITS. The input is stalled from the last
// entry until the last coefficient is taken.
module pauli_basis_decomposition_unit #(
    parameter int QUBITS = pbd_pkg::QUBITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            elem_valid,
    output logic            elem_stall,
    input  pbd_pkg::elem_t  elem,
    output logic            coef_valid,
    input  logic            coef_stall,
    output pbd_pkg::coef_t  coef
);

    localparam int AW      = 2 * QUBITS;
    localparam int ENTRIES = 1 << AW;
    localparam int BFW     = (AW > 2) ? AW - 2 : 1;
    localparam int BF_LAST = (1 << (AW - 2)) - 1;
    localparam int SW      = (QUBITS > 1) ? $clog2(QUBITS) : 1;

    typedef enum logic [3:0] {
        S_LOAD,
        S_RD0,
        S_RD1,
        S_RD2,
        S_WR0,
        S_WR1,
        S_WR2,
        S_WR3,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT
    } state_t;

    state_t               state_reg;
    logic [AW-1:0]        load_cnt_reg;
    logic [BFW-1:0]       bf_reg;
    logic [SW-1:0]        stage_reg;
    logic [AW-1:0]        code_reg;
    logic                 coef_valid_reg;
    pbd_pkg::coef_t       coef_reg;
    pbd_pkg::cval_t       a_reg;
    pbd_pkg::cval_t       b_reg;
    pbd_pkg::cval_t       c_reg;
    pbd_pkg::cval_t       d_reg;

    pbd_pkg::cval_t       mem [ENTRIES];
    pbd_pkg::cval_t       rd0_reg;
    pbd_pkg::cval_t       rd1_reg;

    logic                 we;
    logic [AW-1:0]        wa;
    pbd_pkg::cval_t       wd;
    logic [AW-1:0]        ra0;
    logic [AW-1:0]        ra1;

    logic [AW-1:0]        bf_ext;
    logic [AW-1:0]        rp;
    logic [AW-1:0]        rp_up;
    logic [AW-1:0]        cp_up;
    logic [QUBITS-1:0]    row;
    logic [QUBITS-1:0]    col;
    logic [QUBITS-1:0]    sbit;
    logic [AW-1:0]        ia;
    logic [AW-1:0]        ib;
    logic [AW-1:0]        ic;
    logic [AW-1:0]        id;

    logic [AW-1:0]        emit_code;
    logic [QUBITS-1:0]    erow;
    logic [QUBITS-1:0]    ecol;
    logic                 code_last;
    logic                 load_last;
    logic                 bf_last;
    logic                 stage_last;

    pbd_pkg::alu_req_t    alu_req;
    pbd_pkg::cval_t       alu_res;

    pbd_addsub u_addsub (
        .req (alu_req),
        .res (alu_res)
    );

    // Butterfly addresses: insert a zero at the stage bit into row and column.
    always_comb
    begin
        bf_ext = AW'(bf_reg);
        rp     = bf_ext >> (QUBITS - 1);
        rp_up  = rp << 1;
        cp_up  = bf_ext << 1;
        row    = '0;
        col    = '0;
        for (int j = 0; j < QUBITS; j++)
        begin
            if (j < int'(stage_reg))
            begin
                row[j] = rp[j];
                col[j] = bf_ext[j];
            end
            else if (j > int'(stage_reg))
            begin
                row[j] = rp_up[j];
                col[j] = cp_up[j];
            end
        end
        sbit = QUBITS'(1) << stage_reg;
        ia   = {row, col};
        ib   = {row, col | sbit};
        ic   = {row | sbit, col};
        id   = {row | sbit, col | sbit};
    end

    // Coefficient code to store position: digit j gives row bit (hi) and col bit (lo).
    always_comb
    begin
        emit_code = (state_reg == S_EMIT_WAIT) ? code_reg + 1'b1 : code_reg;
        for (int j = 0; j < QUBITS; j++)
        begin
            erow[j] = emit_code[2*j+1];
            ecol[j] = emit_code[2*j];
        end
    end

    assign code_last  = (code_reg == AW'(ENTRIES - 1));
    assign load_last  = (load_cnt_reg == AW'(ENTRIES - 1));
    assign bf_last    = (bf_reg == BFW'(BF_LAST));
    assign stage_last = (stage_reg == SW'(QUBITS - 1));

    always_comb
    begin
        we          = 1'b0;
        wa          = ia;
        wd.re       = pbd_pkg::DATA_W'(elem.elem_re);
        wd.im       = pbd_pkg::DATA_W'(elem.elem_im);
        ra0         = ia;
        ra1         = ib;
        alu_req.p   = a_reg;
        alu_req.q   = d_reg;
        alu_req.op  = pbd_pkg::ALU_ADD;
        unique case (state_reg) inside
            S_LOAD:
            begin
                we = elem_valid;
                wa = load_cnt_reg;
            end
            S_RD0:
            begin
                ra0 = ia;
                ra1 = ib;
            end
            S_RD1:
            begin
                ra0 = ic;
                ra1 = id;
            end
            S_RD2:
            begin
                we = 1'b0;
            end
            S_WR0:
            begin
                we = 1'b1;
                wa = ia;
                wd = alu_res;
            end
            S_WR1:
            begin
                alu_req.p = b_reg;
                alu_req.q = c_reg;
                we        = 1'b1;
                wa        = ib;
                wd        = alu_res;
            end
            S_WR2:
            begin
                // i(B-C): re = C.im - B.im, im = B.re - C.re
                alu_req.p.re = c_reg.im;
                alu_req.q.re = b_reg.im;
                alu_req.p.im = b_reg.re;
                alu_req.q.im = c_reg.re;
                alu_req.op   = pbd_pkg::ALU_SUB;
                we           = 1'b1;
                wa           = ic;
                wd           = alu_res;
            end
            S_WR3:
            begin
                alu_req.op = pbd_pkg::ALU_SUB;
                we         = 1'b1;
                wa         = id;
                wd         = alu_res;
            end
            S_EMIT_RD, S_EMIT_LD, S_EMIT_WAIT:
            begin
                ra0 = {erow, ecol};
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd0_reg <= mem[ra0];
        rd1_reg <= mem[ra1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            load_cnt_reg   <= '0;
            bf_reg         <= '0;
            stage_reg      <= '0;
            code_reg       <= '0;
            coef_valid_reg <= 1'b0;
            coef_reg       <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            c_reg          <= '0;
            d_reg          <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (elem_valid)
                    begin
                        if (load_last)
                        begin
                            load_cnt_reg <= '0;
                            bf_reg       <= '0;
                            stage_reg    <= '0;
                            state_reg    <= S_RD0;
                        end
                        else
                        begin
                            load_cnt_reg <= load_cnt_reg + 1'b1;
                        end
                    end
                end
                S_RD0:
                begin
                    state_reg <= S_RD1;
                end
                S_RD1:
                begin
                    a_reg     <= rd0_reg;
                    b_reg     <= rd1_reg;
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    c_reg     <= rd0_reg;
                    d_reg     <= rd1_reg;
                    state_reg <= S_WR0;
                end
                S_WR0:
                begin
                    state_reg <= S_WR1;
                end
                S_WR1:
                begin
                    state_reg <= S_WR2;
                end
                S_WR2:
                begin
                    state_reg <= S_WR3;
                end
                S_WR3:
                begin
                    if (bf_last)
                    begin
                        bf_reg <= '0;
                        if (stage_last)
                        begin
                            stage_reg <= '0;
                            code_reg  <= '0;
                            state_reg <= S_EMIT_RD;
                        end
                        else
                        begin
                            stage_reg <= stage_reg + 1'b1;
                            state_reg <= S_RD0;
                        end
                    end
                    else
                    begin
                        bf_reg    <= bf_reg + 1'b1;
                        state_reg <= S_RD0;
                    end
                end
                S_EMIT_RD:
                begin
                    state_reg <= S_EMIT_LD;
                end
                S_EMIT_LD:
                begin
                    coef_reg.pauli_code <= pbd_pkg::CODE_W'(code_reg);
                    coef_reg.coef_re    <= rd0_reg.re;
                    coef_reg.coef_im    <= rd0_reg.im;
                    coef_reg.is_last    <= code_last;
                    coef_valid_reg      <= 1'b1;
                    state_reg           <= S_EMIT_WAIT;
                end
                S_EMIT_WAIT:
                begin
                    if (!coef_stall)
                    begin
                        coef_valid_reg <= 1'b0;
                        if (code_last)
                        begin
                            code_reg  <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            code_reg  <= code_reg + 1'b1;
                            state_reg <= S_EMIT_LD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign elem_stall = (state_reg != S_LOAD);
    assign coef_valid = coef_valid_reg;
    assign coef       = coef_reg;

endmodule

// ===== sv/pbd_checker.sv =====
// Port-level checks for the Pauli basis decomposition unit, bound to the top level.
module pbd_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           elem_valid,
    input logic           elem_stall,
    input pbd_pkg::elem_t elem,
    input logic           coef_valid,
    input logic           coef_stall,
    input pbd_pkg::coef_t coef
);

    logic coef_beat;

    assign coef_beat = coef_valid && !coef_stall;

    // A held coefficient beat keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        coef_valid && coef_stall |=> coef_valid && $stable(coef))
        else $error("coefficient beat changed while stalled");

    // A stalled matrix entry stays presented and unchanged.
    a_elem_hold: assert property (@(posedge clk) disable iff (!rst_n)
        elem_valid && elem_stall |=> elem_valid && $stable(elem))
        else $error("matrix entry changed while stalled");

    // No matrix entry is taken while coefficients are being delivered.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        coef_valid |-> elem_stall)
        else $error("input accepted during coefficient output");

    // After the final coefficient the output goes quiet.
    a_last_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        coef_beat && coef.is_last |=> !coef_valid)
        else $error("output continued past the last coefficient");

    // Codes advance by one between consecutive coefficients.
    a_code_step: assert property (@(posedge clk) disable iff (!rst_n)
        coef_beat && !coef.is_last |-> ##2
            (coef_valid && (coef.pauli_code ==
                pbd_pkg::CODE_W'($past(coef.pauli_code, 2) + 1'b1))))
        else $error("pauli_code did not advance by one");

endmodule

bind pauli_basis_decomposition_unit pbd_checker u_pbd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .elem_valid (elem_valid),
    .elem_stall (elem_stall),
    .elem       (elem),
    .coef_valid (coef_valid),
    .coef_stall (coef_stall),
    .coef       (coef)
);
